// ===== rtl/sorc_pkg.sv =====
// Package for the sequence order rule checker.
// Holds the payload, configuration and code types shared by all RTL files.
// No dependencies.
package sorc_pkg;

   // Symbol alphabet size and field widths
   localparam int NUM_SYMBOLS_DEFAULT = 8;
   localparam int SYMBOL_WIDTH        = 3;
   localparam int MAX_SYMBOLS         = 1 << SYMBOL_WIDTH;
   localparam int MATRIX_WIDTH        = MAX_SYMBOLS * MAX_SYMBOLS;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int CSR_DATA_WIDTH      = 64;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_START_ENABLE = 3'd0,
      CSR_START_SYMBOL = 3'd1,
      CSR_START_NEGATE = 3'd2,
      CSR_END_ENABLE   = 3'd3,
      CSR_END_SYMBOL   = 3'd4,
      CSR_END_NEGATE   = 3'd5,
      CSR_PRECEDENCE   = 3'd6
   } csr_index_type;

   // Result codes
   typedef enum logic [1:0] {
      FAIL_NONE       = 2'd0,
      FAIL_START      = 2'd1,
      FAIL_END        = 2'd2,
      FAIL_PRECEDENCE = 2'd3
   } fail_code_type;

   // One request: a symbol of the candidate ordering
   typedef struct packed {
      logic [SYMBOL_WIDTH-1:0] symbol;
      logic                    last;
   } request_type;

   // One response: verdict for a complete ordering
   typedef struct packed {
      logic       accepted;
      logic [1:0] fail_code;
   } response_type;

   // Rule configuration as seen by the checker
   typedef struct packed {
      logic                    start_enable;
      logic [SYMBOL_WIDTH-1:0] start_symbol;
      logic                    start_negate;
      logic                    end_enable;
      logic [SYMBOL_WIDTH-1:0] end_symbol;
      logic                    end_negate;
      logic [MATRIX_WIDTH-1:0] precedence_matrix;
   } config_type;

endpackage

// ===== rtl/sorc_csr.sv =====
// Configuration registers of the sequence order rule checker.
// Decodes writes by register index; depends on sorc_pkg.
module sorc_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sorc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [sorc_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output sorc_pkg::config_type                  cfg
);

   sorc_pkg::config_type cfg_ff, cfg_in;

   // Writes are always taken; unknown indexes leave the registers alone.
   assign csr_ready = 1'b1;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (sorc_pkg::csr_index_type'(csr_index))
            sorc_pkg::CSR_START_ENABLE: cfg_in.start_enable = csr_wdata[0];
            sorc_pkg::CSR_START_SYMBOL:
               cfg_in.start_symbol = csr_wdata[sorc_pkg::SYMBOL_WIDTH-1:0];
            sorc_pkg::CSR_START_NEGATE: cfg_in.start_negate = csr_wdata[0];
            sorc_pkg::CSR_END_ENABLE:   cfg_in.end_enable = csr_wdata[0];
            sorc_pkg::CSR_END_SYMBOL:
               cfg_in.end_symbol = csr_wdata[sorc_pkg::SYMBOL_WIDTH-1:0];
            sorc_pkg::CSR_END_NEGATE:   cfg_in.end_negate = csr_wdata[0];
            sorc_pkg::CSR_PRECEDENCE:
               cfg_in.precedence_matrix = csr_wdata[sorc_pkg::MATRIX_WIDTH-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/sorc_check.sv =====
// Per-ordering run state and rule evaluation of the sequence order rule checker.
// Consumes one symbol per cycle while item_valid is set and forms the verdict on the last one; depends on sorc_pkg.
module sorc_check #(
   parameter int NUM_SYMBOLS = sorc_pkg::NUM_SYMBOLS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sorc_pkg::config_type  cfg,
   input  logic                  item_valid,
   input  sorc_pkg::request_type item,
   output sorc_pkg::response_type result
);

   logic [NUM_SYMBOLS-1:0]            seen_ff, seen_in;
   logic                              first_ff, first_in;
   logic                              start_fail_ff, start_fail_in;
   logic                              order_fail_ff, order_fail_in;

   logic [sorc_pkg::MAX_SYMBOLS-1:0]  sym_onehot;
   logic [NUM_SYMBOLS-1:0]            sym_bit;
   logic [NUM_SYMBOLS-1:0]            seen_next;
   logic [NUM_SYMBOLS-1:0]            rows [NUM_SYMBOLS];
   logic [NUM_SYMBOLS-1:0]            sym_row;
   logic                              first_occurrence;
   logic                              start_fail_now;
   logic                              end_fail_now;
   logic                              pair_fail_now;
   logic                              missing_fail;
   logic                              start_fail_all;
   logic                              order_fail_all;
   sorc_pkg::fail_code_type           code;

   // Precedence rows, each limited to the symbols in use
   always_comb begin
      for (int s = 0; s < NUM_SYMBOLS; s++) begin
         rows[s] = cfg.precedence_matrix[s*sorc_pkg::MAX_SYMBOLS +: NUM_SYMBOLS];
      end
   end

   // Symbol decode; an out-of-range symbol decodes to no bit at all.
   assign sym_onehot = sorc_pkg::MAX_SYMBOLS'(1) << item.symbol;
   assign sym_bit    = sym_onehot[NUM_SYMBOLS-1:0];
   assign seen_next  = seen_ff | sym_bit;
   assign first_occurrence = (sym_bit != '0) && ((seen_ff & sym_bit) == '0);

   // Row of the current symbol, taken from its one-hot code
   always_comb begin
      sym_row = '0;
      for (int s = 0; s < NUM_SYMBOLS; s++) begin
         if (sym_bit[s]) begin
            sym_row = rows[s];
         end
      end
   end

   // A first occurrence fails if any required predecessor is still unseen.
   assign pair_fail_now = first_occurrence && ((sym_row & ~seen_next) != '0);

   // Start and end rules: fail when equality matches the negate option.
   assign start_fail_now = first_ff && cfg.start_enable &&
                           ((item.symbol == cfg.start_symbol) == cfg.start_negate);
   assign end_fail_now   = cfg.end_enable &&
                           ((item.symbol == cfg.end_symbol) == cfg.end_negate);

   // At the end every symbol with predecessors must have shown up.
   always_comb begin
      missing_fail = 1'b0;
      for (int s = 0; s < NUM_SYMBOLS; s++) begin
         if (!seen_next[s] && (rows[s] != '0)) begin
            missing_fail = 1'b1;
         end
      end
   end

   assign start_fail_all = start_fail_ff | start_fail_now;
   assign order_fail_all = order_fail_ff | pair_fail_now | missing_fail;

   // Verdict in priority order start, end, precedence
   always_comb begin
      if (start_fail_all) begin
         code = sorc_pkg::FAIL_START;
      end else if (end_fail_now) begin
         code = sorc_pkg::FAIL_END;
      end else if (order_fail_all) begin
         code = sorc_pkg::FAIL_PRECEDENCE;
      end else begin
         code = sorc_pkg::FAIL_NONE;
      end
   end

   assign result.accepted  = (code == sorc_pkg::FAIL_NONE);
   assign result.fail_code = code;

   // Run state update; the last symbol returns everything to the idle values.
   always_comb begin
      seen_in       = seen_ff;
      first_in      = first_ff;
      start_fail_in = start_fail_ff;
      order_fail_in = order_fail_ff;
      if (item_valid) begin
         if (item.last) begin
            seen_in       = '0;
            first_in      = 1'b1;
            start_fail_in = 1'b0;
            order_fail_in = 1'b0;
         end else begin
            seen_in       = seen_next;
            first_in      = 1'b0;
            start_fail_in = start_fail_all;
            order_fail_in = order_fail_ff | pair_fail_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff       <= '0;
         first_ff      <= 1'b1;
         start_fail_ff <= 1'b0;
         order_fail_ff <= 1'b0;
      end else begin
         seen_ff       <= seen_in;
         first_ff      <= first_in;
         start_fail_ff <= start_fail_in;
         order_fail_ff <= order_fail_in;
      end
   end

endmodule

// ===== rtl/sequence_order_rule_checker_core.sv =====
// Top level of the sequence order rule checker.
// Input register, checker and result register; depends on sorc_pkg, sorc_csr, sorc_check.
//
// Usage:
//   The req_ channel carries one symbol of a candidate ordering per request;
//   the request with last set closes the ordering. Each closed ordering gives
//   exactly one response on the rsp_ channel: accepted, plus a fail code for
//   the first failing check (start rule, end rule, then precedence).
//   Requests without last give no response.
//   The csr_ channel writes the rule registers by index; it is always ready.
//   Write it only while no ordering is in flight.
// Timing:
//   Throughput is one request per cycle unless a last request is held back
//   (see Stalls). A response is formed as its last request moves from the
//   input register through the checker straight into the result register.
// Reset:
//   Clears all rule registers and the run state; both stages come up empty.
// Stalls:
//   While a response waits in the result register, requests without last
//   still flow through; a last request waits in the input register until
//   the result register frees up, and the req_ channel then holds off.
module sequence_order_rule_checker_core #(
   parameter int NUM_SYMBOLS = sorc_pkg::NUM_SYMBOLS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  sorc_pkg::request_type                req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output sorc_pkg::response_type               rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sorc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [sorc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   sorc_pkg::config_type   cfg;
   sorc_pkg::request_type  item_ff, item_in;
   logic                   item_valid_ff, item_valid_in;
   sorc_pkg::response_type rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   sorc_pkg::response_type result;
   logic                   consume;

   // Rule registers
   sorc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The held symbol moves on unless it closes an ordering and the result
   // register is still occupied.
   assign consume   = item_valid_ff &&
                      (!item_ff.last || !rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || consume;

   // Input register
   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      if (req_ready) begin
         item_in       = req_data;
         item_valid_in = req_valid;
      end
   end

   // Rule evaluation and run state
   sorc_check #(
      .NUM_SYMBOLS (NUM_SYMBOLS)
   ) u_check (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (consume),
      .item       (item_ff),
      .result     (result)
   );

   // Result register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (consume && item_ff.last) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
